// ===== rtl/bfra_pkg.sv =====
// ============================================================================
// bfra_pkg : best-fit range allocator shared types
// Beat payload structs, table entry layouts, status and op codes.
// ============================================================================
`default_nettype none

package bfra_pkg;

   // page geometry (port widths are fixed by these)
   localparam int MAX_SLOTS = 1024;
   localparam int SLOT_W    = 10;
   localparam int LEN_W     = 11;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(2 * MAX_SLOTS - 1);

   // request opcodes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_QFULL  = 2'd2;
   localparam logic [1:0] ST_TFULL  = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [LEN_W-1:0]  slot_count;
      logic [SLOT_W-1:0] slot_offset;
      logic [63:0]       frame;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] alloc_offset;
      logic [LEN_W-1:0]  free_total;
   } rsp_type;

   // one free block
   typedef struct packed {
      logic [SLOT_W-1:0] start;
      logic [LEN_W-1:0]  len;
   } blk_type;

   // one deferred free
   typedef struct packed {
      logic [SLOT_W-1:0] start;
      logic [LEN_W-1:0]  len;
      logic [63:0]       frame;
   } pend_type;

   // saturate a grown length back to the cap
   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W+1:0] s);
      logic [LEN_W-1:0] r;
      r = (s > {2'b00, LEN_CAP}) ? LEN_CAP : s[LEN_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/best_fit_range_allocator_core.sv =====
// ============================================================================
// best_fit_range_allocator_core : best-fit slot allocator with deferred free
// Sequencer walking a free-block table and a deferred-free queue, both RAMs.
// ============================================================================
//  channel | ports                               | direction | flow control
//  req     | start, busy, req_item               | in        | start & !busy
//  rsp     | rsp_strobe, rsp_item                | out       | strobe, no stall
//  csr     | csr_valid, csr_ready, csr_data      | in        | valid & ready
//
//  Allocate: one table scan, then a shift of the entries above the taken
//  block, one table RAM port each way. Free: one queue append. Release:
//  per drained entry a head read and check, a neighbour scan, up to two
//  shifts and one append. Reset (and every csr beat) rewrites table entry
//  0 in S_INIT; busy is high and csr_ready low meanwhile. Results cannot
//  be stalled.
// ============================================================================
`default_nettype none

module best_fit_range_allocator_core #(
   parameter int MAX_FREE_BLOCKS = 64,
   parameter int PENDING_DEPTH   = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire bfra_pkg::req_type             req_item,
   output logic                               rsp_strobe,
   output bfra_pkg::rsp_type                  rsp_item,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bfra_pkg::LEN_W-1:0]    csr_data
);

   localparam int TW = $clog2(MAX_FREE_BLOCKS);
   localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
   localparam int PW = $clog2(PENDING_DEPTH);
   localparam int UW = $clog2(PENDING_DEPTH + 1);
   localparam int SW = bfra_pkg::SLOT_W;
   localparam int LW = bfra_pkg::LEN_W;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_ASCAN, S_QRD, S_QCHK, S_NSCAN, S_NDEC,
      S_DROP, S_APPEND, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [LW-1:0]       page_ff, page_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [LW-1:0]       free_ff, free_in;
   logic [PW-1:0]       head_ff, head_in;
   logic [UW-1:0]       used_ff, used_in;
   bfra_pkg::req_type   req_ff, req_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                rv_ff, rv_in;
   logic [CW-1:0]       ridx_ff, ridx_in;
   logic                pv_ff, pv_in, nv_ff, nv_in;
   logic [TW-1:0]       pidx_ff, pidx_in, nidx_ff, nidx_in;
   bfra_pkg::blk_type   pblk_ff, pblk_in, nblk_ff, nblk_in;
   logic                drop2_ff, drop2_in;
   logic [TW-1:0]       drop2_idx_ff, drop2_idx_in;
   logic                app_en_ff, app_en_in;
   bfra_pkg::blk_type   app_ff, app_in;
   logic [1:0]          status_ff, status_in;
   logic [SW-1:0]       grant_ff, grant_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   bfra_pkg::rsp_type   rsp_ff, rsp_in;

   // RAM ports
   logic                tbl_we, tbl_re;
   logic [TW-1:0]       tbl_wa, tbl_ra;
   bfra_pkg::blk_type   tbl_wd, tbl_rd;
   logic                pq_we, pq_re;
   logic [PW-1:0]       pq_wa, pq_ra;
   bfra_pkg::pend_type  pq_wd, pq_rd;

   bfra_ram #(.WIDTH($bits(bfra_pkg::blk_type)), .DEPTH(MAX_FREE_BLOCKS)) u_tbl (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_en   (tbl_re),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   bfra_ram #(.WIDTH($bits(bfra_pkg::pend_type)), .DEPTH(PENDING_DEPTH)) u_pq (
      .clock   (clock),
      .wr_en   (pq_we),
      .wr_addr (pq_wa),
      .wr_data (pq_wd),
      .rd_en   (pq_re),
      .rd_addr (pq_ra),
      .rd_data (pq_rd)
   );

   // sequencer next state
   always_comb begin
      logic [UW:0]    tail;
      logic [CW-1:0]  rprev;
      logic [SW+1:0]  psum;
      logic [SW+1:0]  nsum;
      logic           padj, nadj;
      logic [LW+1:0]  ntot;
      logic [LW-1:0]  clamp;

      state_in      = state_ff;
      page_in       = page_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      rv_in         = 1'b0;
      ridx_in       = ridx_ff;
      pv_in         = pv_ff;
      nv_in         = nv_ff;
      pidx_in       = pidx_ff;
      nidx_in       = nidx_ff;
      pblk_in       = pblk_ff;
      nblk_in       = nblk_ff;
      drop2_in      = drop2_ff;
      drop2_idx_in  = drop2_idx_ff;
      app_en_in     = app_en_ff;
      app_in        = app_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      tbl_we = 1'b0;
      tbl_wa = '0;
      tbl_wd = '0;
      tbl_re = 1'b0;
      tbl_ra = idx_ff[TW-1:0];
      pq_we  = 1'b0;
      pq_wa  = '0;
      pq_wd  = '0;
      pq_re  = 1'b0;
      pq_ra  = head_ff;

      tail  = {1'b0, used_ff} + (UW + 1)'(head_ff);
      rprev = ridx_ff - 1'b1;
      psum  = (SW + 2)'(pblk_ff.start) + (SW + 2)'(pblk_ff.len);
      nsum  = (SW + 2)'(pq_rd.start) + (SW + 2)'(pq_rd.len);
      padj  = pv_ff && (psum == (SW + 2)'(pq_rd.start));
      nadj  = nv_ff && (nsum == (SW + 2)'(nblk_ff.start));
      ntot  = (LW + 2)'(pq_rd.len) + (padj ? (LW + 2)'(pblk_ff.len) : '0)
              + (nadj ? (LW + 2)'(nblk_ff.len) : '0);
      clamp = (csr_data == '0) ? LW'(1)
            : (csr_data > LW'(bfra_pkg::MAX_SLOTS)) ? LW'(bfra_pkg::MAX_SLOTS) : csr_data;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               page_in  = clamp;
               state_in = S_INIT;
            end else if (start) begin
               req_in    = req_item;
               status_in = bfra_pkg::ST_OK;
               grant_in  = '0;
               idx_in    = '0;
               pv_in     = 1'b0;
               nv_in     = 1'b0;
               state_in  = S_DONE;
               case (req_item.op)
                  bfra_pkg::OP_ALLOC: begin
                     if (req_item.slot_count == '0 || req_item.slot_count > free_ff) begin
                        status_in = bfra_pkg::ST_NOFIT;
                     end else begin
                        state_in = S_ASCAN;
                     end
                  end
                  bfra_pkg::OP_FREE: begin
                     if (used_ff >= UW'(PENDING_DEPTH)) begin
                        status_in = bfra_pkg::ST_QFULL;
                     end else begin
                        pq_we   = 1'b1;
                        pq_wa   = (tail >= (UW + 1)'(PENDING_DEPTH))
                                ? PW'(tail - (UW + 1)'(PENDING_DEPTH)) : PW'(tail);
                        pq_wd   = '{start: req_item.slot_offset,
                                    len:   req_item.slot_count,
                                    frame: req_item.frame};
                        used_in = used_ff + 1'b1;
                     end
                  end
                  bfra_pkg::OP_RELEASE: begin
                     state_in = S_QRD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // page (re)initialisation: one block covering the page
         S_INIT: begin
            tbl_we   = 1'b1;
            tbl_wa   = '0;
            tbl_wd   = '{start: '0, len: page_ff};
            cnt_in   = CW'(1);
            free_in  = page_ff;
            head_in  = '0;
            used_in  = '0;
            state_in = S_IDLE;
         end

         // best-fit scan, one entry per cycle
         S_ASCAN: begin
            if (idx_ff < cnt_ff) begin
               tbl_re  = 1'b1;
               rv_in   = 1'b1;
               ridx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end
            if (rv_ff && tbl_rd.len >= req_ff.slot_count &&
                (!pv_ff || tbl_rd.len < pblk_ff.len)) begin
               pv_in   = 1'b1;
               pidx_in = ridx_ff[TW-1:0];
               pblk_in = tbl_rd;
            end
            if (idx_ff >= cnt_ff && !rv_ff) begin
               if (!pv_ff) begin
                  status_in = bfra_pkg::ST_NOFIT;
                  state_in  = S_DONE;
               end else begin
                  free_in      = free_ff - req_ff.slot_count;
                  grant_in     = pblk_ff.start;
                  app_in.start = pblk_ff.start + req_ff.slot_count[SW-1:0];
                  app_in.len   = pblk_ff.len - req_ff.slot_count;
                  app_en_in    = (pblk_ff.len != req_ff.slot_count);
                  drop2_in     = 1'b0;
                  idx_in       = CW'(pidx_ff) + 1'b1;
                  state_in     = S_DROP;
               end
            end
         end

         // read the queue head
         S_QRD: begin
            if (used_ff == '0) begin
               state_in = S_DONE;
            end else begin
               pq_re    = 1'b1;
               state_in = S_QCHK;
            end
         end

         S_QCHK: begin
            if (pq_rd.frame > req_ff.frame) begin
               state_in = S_DONE;
            end else if (pq_rd.len == '0) begin
               head_in  = (head_ff == PW'(PENDING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               used_in  = used_ff - 1'b1;
               state_in = S_QRD;
            end else begin
               pv_in    = 1'b0;
               nv_in    = 1'b0;
               idx_in   = '0;
               state_in = S_NSCAN;
            end
         end

         // neighbour scan: closest start at or below, closest above
         S_NSCAN: begin
            if (idx_ff < cnt_ff) begin
               tbl_re  = 1'b1;
               rv_in   = 1'b1;
               ridx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end
            if (rv_ff) begin
               if (tbl_rd.start <= pq_rd.start) begin
                  if (!pv_ff || tbl_rd.start > pblk_ff.start) begin
                     pv_in   = 1'b1;
                     pidx_in = ridx_ff[TW-1:0];
                     pblk_in = tbl_rd;
                  end
               end else if (!nv_ff || tbl_rd.start < nblk_ff.start) begin
                  nv_in   = 1'b1;
                  nidx_in = ridx_ff[TW-1:0];
                  nblk_in = tbl_rd;
               end
            end
            if (idx_ff >= cnt_ff && !rv_ff) begin
               state_in = S_NDEC;
            end
         end

         // merge decision
         S_NDEC: begin
            if (!padj && !nadj && cnt_ff >= CW'(MAX_FREE_BLOCKS)) begin
               status_in = bfra_pkg::ST_TFULL;
               state_in  = S_DONE;
            end else begin
               free_in      = bfra_pkg::sat_len((LW + 2)'(free_ff) + (LW + 2)'(pq_rd.len));
               app_en_in    = 1'b1;
               app_in.start = padj ? pblk_ff.start : pq_rd.start;
               app_in.len   = bfra_pkg::sat_len(ntot);
               drop2_in     = 1'b0;
               state_in     = S_DROP;
               if (padj && nadj) begin
                  // higher index first so the lower one stays put
                  idx_in       = CW'((pidx_ff > nidx_ff) ? pidx_ff : nidx_ff) + 1'b1;
                  drop2_in     = 1'b1;
                  drop2_idx_in = (pidx_ff > nidx_ff) ? nidx_ff : pidx_ff;
               end else if (padj) begin
                  idx_in = CW'(pidx_ff) + 1'b1;
               end else if (nadj) begin
                  idx_in = CW'(nidx_ff) + 1'b1;
               end else begin
                  state_in = S_APPEND;
               end
            end
         end

         // remove an entry by shifting the ones above it down
         S_DROP: begin
            if (idx_ff < cnt_ff) begin
               tbl_re  = 1'b1;
               rv_in   = 1'b1;
               ridx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end
            if (rv_ff) begin
               tbl_we = 1'b1;
               tbl_wa = rprev[TW-1:0];
               tbl_wd = tbl_rd;
            end
            if (idx_ff >= cnt_ff && !rv_ff) begin
               cnt_in = cnt_ff - 1'b1;
               if (drop2_ff) begin
                  drop2_in = 1'b0;
                  idx_in   = CW'(drop2_idx_ff) + 1'b1;
               end else begin
                  state_in = S_APPEND;
               end
            end
         end

         // newest free block goes at the end
         S_APPEND: begin
            if (app_en_ff && cnt_ff < CW'(MAX_FREE_BLOCKS)) begin
               tbl_we = 1'b1;
               tbl_wa = cnt_ff[TW-1:0];
               tbl_wd = app_ff;
               cnt_in = cnt_ff + 1'b1;
            end
            if (req_ff.op == bfra_pkg::OP_RELEASE) begin
               head_in  = (head_ff == PW'(PENDING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               used_in  = used_ff - 1'b1;
               state_in = S_QRD;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.alloc_offset = grant_ff;
            rsp_in.free_total   = free_ff;
            state_in            = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         page_ff       <= LW'(bfra_pkg::MAX_SLOTS);
         cnt_ff        <= CW'(1);
         free_ff       <= LW'(bfra_pkg::MAX_SLOTS);
         head_ff       <= '0;
         used_ff       <= '0;
         rv_ff         <= 1'b0;
         pv_ff         <= 1'b0;
         nv_ff         <= 1'b0;
         drop2_ff      <= 1'b0;
         app_en_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_ff       <= page_in;
         cnt_ff        <= cnt_in;
         free_ff       <= free_in;
         head_ff       <= head_in;
         used_ff       <= used_in;
         rv_ff         <= rv_in;
         pv_ff         <= pv_in;
         nv_ff         <= nv_in;
         drop2_ff      <= drop2_in;
         app_en_ff     <= app_en_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      ridx_ff      <= ridx_in;
      pidx_ff      <= pidx_in;
      nidx_ff      <= nidx_in;
      pblk_ff      <= pblk_in;
      nblk_ff      <= nblk_in;
      drop2_idx_ff <= drop2_idx_in;
      app_ff       <= app_in;
      status_ff    <= status_in;
      grant_ff     <= grant_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(PENDING_DEPTH))
      else $error("queue occupancy beyond depth");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_FREE_BLOCKS))
      else $error("block count beyond table size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_DONE))
      else $error("response beat without completion");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_strobe_ff && !busy)
      else $error("completion lost its response beat");

endmodule

`default_nettype wire

// ===== rtl/bfra_ram.sv =====
// ============================================================================
// bfra_ram : simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module bfra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
